FILE: src/padded_block_formatter_checksum_assert.svh
// Assertion macros shared by the checker of the padded block formatter.
`ifndef PADDED_BLOCK_FORMATTER_CHECKSUM_ASSERT_SVH
`define PADDED_BLOCK_FORMATTER_CHECKSUM_ASSERT_SVH

// Same-cycle implication; the consequent may carry its own cycle delay.
`define PBFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("pbfc checker: property failed");

// Next-cycle implication.
`define PBFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbfc checker: property failed");

`endif

FILE: src/pbfc_pkg.sv
// Package of the padded block formatter: constants, control types and the checksum step.
package pbfc_pkg;

  localparam int MAX_BLOCK_DEF = 256;
  localparam int SIZE_RESET    = 128;
  localparam int SIZE_MIN      = 8;
  localparam int HDR_LEN       = 5;

  localparam logic [7:0] PAD_BYTE   = 8'h55;
  localparam logic [7:0] FMT_PADDED = 8'h03;
  localparam logic [7:0] FMT_PLAIN  = 8'h02;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PAD
  } state_t;

  typedef struct packed {
    logic do_push;
    logic do_read;
    logic do_pad;
  } cmd_t;

  typedef struct packed {
    logic pad_start;
    logic pad_last;
  } sts_t;

  // One checksum step: rotate left by one, then add the byte, modulo 2^16.
  function automatic logic [15:0] fold(input logic [15:0] s, input logic [7:0] b);
    return {s[14:0], s[15]} + {8'h00, b};
  endfunction

endpackage

FILE: src/pbfc_ctrl.sv
// Controller state machine of the padded block formatter.
module pbfc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           req_type,
  input  pbfc_pkg::sts_t sts,
  output pbfc_pkg::cmd_t cmd,
  output logic           busy
);
  import pbfc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && req_type) begin
          state_next = S_READ;
        end else if (start && sts.pad_start) begin
          state_next = S_PAD;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      S_PAD: begin
        if (sts.pad_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.do_push = start && !req_type;
      end
      S_READ: begin
        cmd.do_read = 1'b1;
      end
      S_PAD: begin
        cmd.do_pad = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: src/pbfc_dp.sv
// Datapath of the padded block formatter: payload memory, counters, checksum and result registers.
module pbfc_dp #(
  parameter int MAX_BLOCK = pbfc_pkg::MAX_BLOCK_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pbfc_pkg::cmd_t cmd,
  output pbfc_pkg::sts_t sts,
  input  logic           cfg_wr,
  input  logic [8:0]     cfg_data,
  input  logic [7:0]     data_byte,
  input  logic           data_last,
  output logic           done,
  output logic [7:0]     out_byte,
  output logic           block_end,
  output logic [1:0]     status
);
  import pbfc_pkg::*;

  localparam int SW = $clog2(MAX_BLOCK + 1);
  localparam int AW = $clog2(MAX_BLOCK);
  localparam int SIZE_RST = (SIZE_RESET > MAX_BLOCK) ? MAX_BLOCK : SIZE_RESET;

  logic [7:0]    mem [MAX_BLOCK];
  logic [7:0]    rd_data;

  logic [SW-1:0] size;
  logic [SW-1:0] count;
  logic [SW-1:0] rdpos;
  logic [SW-1:0] pad_left;
  logic [15:0]   sum;
  logic          ready;
  logic          ovf;

  logic [SW-1:0] cap;
  logic [SW-1:0] pad_cur;
  logic [SW-1:0] base_cnt;
  logic [15:0]   base_sum;
  logic          ovf_now;
  logic [SW-1:0] cnt_push;
  logic [15:0]   sum_push;
  logic [SW-1:0] pad_push;
  logic [SW-1:0] rd_off;
  logic [AW-1:0] rd_addr;
  logic [31:0]   size_div;
  logic [31:0]   pad_ext;
  logic          at_end;
  logic [7:0]    rd_byte;
  logic [31:0]   cfg_ext;

  assign cap      = size - SW'(HDR_LEN);
  assign pad_cur  = cap - count;
  assign pad_ext  = 32'(pad_cur);
  assign size_div = 32'(size) >> 3;
  assign cfg_ext  = 32'(cfg_data);

  // A push onto a finished block starts a fresh message.
  assign base_cnt = ready ? '0 : count;
  assign base_sum = ready ? 16'h0000 : sum;
  assign ovf_now  = (!ready && ovf) || (base_cnt >= cap);
  assign cnt_push = ovf_now ? base_cnt : base_cnt + SW'(1);
  assign sum_push = ovf_now ? base_sum : fold(base_sum, data_byte);
  assign pad_push = cap - cnt_push;

  assign sts.pad_start = data_last && !ovf_now && (pad_push != '0);
  assign sts.pad_last  = (pad_left == SW'(1));

  assign rd_off  = rdpos - SW'(HDR_LEN);
  assign rd_addr = rd_off[AW-1:0];
  assign at_end  = (rdpos == size - SW'(1));

  always_ff @(posedge clk) begin
    if (cmd.do_push && !ovf_now) begin
      mem[base_cnt[AW-1:0]] <= data_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    if (rdpos == SW'(0)) begin
      rd_byte = (pad_cur != '0) ? FMT_PADDED : FMT_PLAIN;
    end else if (rdpos == SW'(1)) begin
      rd_byte = 8'h00;
    end else if (rdpos == SW'(2)) begin
      rd_byte = size_div[7:0];
    end else if (rdpos == SW'(3)) begin
      rd_byte = sum[15:8];
    end else if (rdpos == SW'(4)) begin
      rd_byte = sum[7:0];
    end else if (rd_off < count) begin
      rd_byte = rd_data;
    end else if (at_end) begin
      rd_byte = pad_ext[7:0];
    end else begin
      rd_byte = PAD_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size  <= SW'(SIZE_RST);
      count <= '0;
      sum   <= 16'h0000;
      rdpos <= '0;
      ready <= 1'b0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.do_push || cmd.do_read;
      if (cfg_wr) begin
        if (cfg_ext < 32'(SIZE_MIN)) begin
          size <= SW'(SIZE_MIN);
        end else if (cfg_ext > 32'(MAX_BLOCK)) begin
          size <= SW'(MAX_BLOCK);
        end else begin
          size <= cfg_ext[SW-1:0];
        end
        count <= '0;
        sum   <= 16'h0000;
        rdpos <= '0;
        ready <= 1'b0;
        ovf   <= 1'b0;
      end else if (cmd.do_push) begin
        rdpos <= '0;
        if (data_last && ovf_now) begin
          count <= '0;
          sum   <= 16'h0000;
          ready <= 1'b0;
          ovf   <= 1'b0;
        end else begin
          count <= cnt_push;
          sum   <= sum_push;
          ready <= data_last;
          ovf   <= ovf_now;
        end
      end else if (cmd.do_pad) begin
        // The final pad byte carries the pad count instead of the fill pattern.
        sum <= fold(sum, sts.pad_last ? pad_ext[7:0] : PAD_BYTE);
      end else if (cmd.do_read && ready) begin
        if (at_end) begin
          count <= '0;
          sum   <= 16'h0000;
          rdpos <= '0;
          ready <= 1'b0;
          ovf   <= 1'b0;
        end else begin
          rdpos <= rdpos + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_push) begin
      pad_left <= pad_push;
    end else if (cmd.do_pad) begin
      pad_left <= pad_left - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_push) begin
      out_byte  <= 8'h00;
      block_end <= 1'b0;
      status    <= ovf_now ? STAT_OVERFLOW : STAT_OK;
    end else if (cmd.do_read) begin
      if (ready) begin
        out_byte  <= rd_byte;
        block_end <= at_end;
        status    <= STAT_OK;
      end else begin
        out_byte  <= 8'h00;
        block_end <= 1'b0;
        status    <= STAT_EMPTY;
      end
    end
  end

endmodule

FILE: src/padded_block_formatter_checksum.sv
// Top level of the padded block formatter with rotate-add checksum.
// A push (req_type 0) answers in the cycle after its transfer; busy stays low for it unless
// it closes a message that needs padding, in which case busy stays high while the checksum
// unit folds the pad bytes, one pad byte a cycle. A pull (req_type 1) answers after the
// S_READ state and the done register, and start is taken again in the cycle after the read.
// Each result shows on out_byte, block_end and status for exactly one cycle while done is
// high; the receiver cannot stall it. Writing block_size discards any message or block in
// progress.
module padded_block_formatter_checksum #(
  parameter int MAX_BLOCK = pbfc_pkg::MAX_BLOCK_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic       data_last,
  input  logic       block_size_wr,
  input  logic [8:0] block_size,
  output logic       done,
  output logic [7:0] out_byte,
  output logic       block_end,
  output logic [1:0] status
);
  import pbfc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pbfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  pbfc_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr    (block_size_wr),
    .cfg_data  (block_size),
    .data_byte (data_byte),
    .data_last (data_last),
    .done      (done),
    .out_byte  (out_byte),
    .block_end (block_end),
    .status    (status)
  );

endmodule

FILE: src/pbfc_checker.sv
// Port-level checker of the padded block formatter and its bind to the top level.
`include "padded_block_formatter_checksum_assert.svh"

module pbfc_props (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       req_type,
  input logic       done,
  input logic [7:0] out_byte,
  input logic       block_end,
  input logic [1:0] status
);
  import pbfc_pkg::*;

  `PBFC_ASSERT_NXT(a_push_answers, start && !busy && !req_type, done)
  `PBFC_ASSERT_IMP(a_pull_answers, start && !busy && req_type, ##2 done)
  `PBFC_ASSERT_IMP(a_empty_is_zero, done && status == STAT_EMPTY, (out_byte == 8'h00 && !block_end))
  `PBFC_ASSERT_IMP(a_end_is_ok, done && block_end, (status == STAT_OK))

endmodule

bind padded_block_formatter_checksum pbfc_props u_pbfc_props (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .req_type  (req_type),
  .done      (done),
  .out_byte  (out_byte),
  .block_end (block_end),
  .status    (status)
);

FILE: verif/pbfc_checker.sv
// Checker for the padded block formatter: it predicts every result and compares it with the output.
`timescale 1ns / 100ps
module pbfc_checker #(
  parameter int MAX_BLOCK = pbfc_pkg::MAX_BLOCK_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic       data_last,
  input  logic       block_size_wr,
  input  logic [8:0] block_size,
  input  logic       done,
  input  logic [7:0] out_byte,
  input  logic       block_end,
  input  logic [1:0] status,
  output int         errors,
  output int         pending
);
  import pbfc_pkg::*;

  localparam logic REQ_PUSH = 1'b0;

  typedef struct packed {
    logic [7:0] data;
    logic       final_byte;
    logic [1:0] code;
  } block_out_t;

  block_out_t  due_q[$];
  logic [8:0]  size_cfg = 9'(SIZE_RESET);
  logic [7:0]  msg_mem [MAX_BLOCK];
  int unsigned msg_len;
  logic [15:0] csum;
  int unsigned rd_pos;
  logic        blk_ready;
  logic        ovf_flag;
  int          fails = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [15:0] rot_add(input logic [15:0] s, input logic [7:0] b);
    logic [15:0] r;
    r = (s << 1) | (s >> 15);
    return r + 16'(b);
  endfunction

  function automatic int unsigned size_used();
    if (size_cfg < 9'(SIZE_MIN)) return SIZE_MIN;
    if (size_cfg > 9'(MAX_BLOCK)) return MAX_BLOCK;
    return 32'(size_cfg);
  endfunction

  function automatic void drop_message();
    msg_len   = 0;
    csum      = '0;
    rd_pos    = 0;
    blk_ready = 1'b0;
    ovf_flag  = 1'b0;
  endfunction

  function automatic block_out_t predict(input logic req, input logic [7:0] b, input logic last);
    int unsigned sz;
    int unsigned cap;
    int unsigned pad;
    block_out_t  res;
    sz       = size_used();
    cap      = sz - HDR_LEN;
    res      = '0;
    res.code = STAT_OK;
    if (req == REQ_PUSH) begin
      // A push onto a finished block starts a fresh message.
      if (blk_ready) drop_message();
      if (ovf_flag || msg_len >= cap) begin
        ovf_flag = 1'b1;
        res.code = STAT_OVERFLOW;
      end else begin
        msg_mem[msg_len] = b;
        msg_len++;
        csum = rot_add(csum, b);
      end
      if (last) begin
        if (ovf_flag) begin
          drop_message();
        end else begin
          pad = cap - msg_len;
          for (int unsigned j = 0; j < pad; j++) begin
            csum = rot_add(csum, (j + 1 == pad) ? 8'(pad) : PAD_BYTE);
          end
          rd_pos    = 0;
          blk_ready = 1'b1;
        end
      end
    end else if (!blk_ready) begin
      res.code = STAT_EMPTY;
    end else begin
      pad = cap - msg_len;
      case (rd_pos)
        0: res.data = (pad != 0) ? FMT_PADDED : FMT_PLAIN;
        1: res.data = 8'h00;
        2: res.data = 8'(sz / 8);
        3: res.data = csum[15:8];
        4: res.data = csum[7:0];
        default: begin
          if (rd_pos < HDR_LEN + msg_len) res.data = msg_mem[rd_pos - HDR_LEN];
          else if (rd_pos + 1 >= sz) res.data = 8'(pad);
          else res.data = PAD_BYTE;
        end
      endcase
      if (rd_pos + 1 >= sz) begin
        res.final_byte = 1'b1;
        drop_message();
      end else begin
        rd_pos++;
      end
    end
    return res;
  endfunction

  function automatic void report(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fails++;
  endfunction

  always @(posedge clk) begin
    block_out_t want;
    if (rst) begin
      size_cfg = 9'(SIZE_RESET);
      drop_message();
      due_q.delete();
    end else begin
      if (done) begin
        if (due_q.size() == 0) begin
          $display("%0t: result with none expected, actual %0h/%0h/%0h", $time, out_byte,
                   block_end, status);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (out_byte !== want.data) report("out_byte", want.data, out_byte);
          if (block_end !== want.final_byte) report("block_end", want.final_byte, block_end);
          if (status !== want.code) report("status", want.code, status);
        end
      end
      if (block_size_wr) begin
        size_cfg = block_size;
        drop_message();
      end
      if (start && !busy) due_q.push_back(predict(req_type, data_byte, data_last));
    end
    pending <= due_q.size();
    errors  <= fails;
  end

endmodule

FILE: verif/tb_top.sv
// Top of the padded block formatter testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
  import pbfc_pkg::*;

  localparam logic REQ_PUSH       = 1'b0;
  localparam logic REQ_PULL       = 1'b1;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   DRAIN_CYCLES   = 300;
  localparam int   PHASE_ITEMS    = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       req_type = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       data_last = 1'b0;
  logic       block_size_wr = 1'b0;
  logic [8:0] block_size = 9'd0;
  logic       done;
  logic [7:0] out_byte;
  logic       block_end;
  logic [1:0] status;
  int         fail_count;
  int         pending_count;

  int burst_left = 0;
  int items_sent = 0;
  int cur_size = SIZE_RESET;
  int stall_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  padded_block_formatter_checksum i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .data_last    (data_last),
    .block_size_wr(block_size_wr),
    .block_size   (block_size),
    .done         (done),
    .out_byte     (out_byte),
    .block_end    (block_end),
    .status       (status)
  );

  pbfc_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .data_last    (data_last),
    .block_size_wr(block_size_wr),
    .block_size   (block_size),
    .done         (done),
    .out_byte     (out_byte),
    .block_end    (block_end),
    .status       (status),
    .errors       (fail_count),
    .pending      (pending_count)
  );

  // The run ends here if nothing is transferred for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The sender works in bursts; a new burst may open with a gap of idle cycles.
  task automatic send_item(input logic req, input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start     <= 1'b1;
    req_type  <= req;
    data_byte <= b;
    data_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_count != 0 || busy);
    // A closing push may still be folding pad bytes after its result.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [8:0] v);
    wait_idle();
    block_size_wr <= 1'b1;
    block_size    <= v;
    @(posedge clk);
    block_size_wr <= 1'b0;
    block_size    <= 9'($urandom_range(0, 511));
    cur_size = (v < SIZE_MIN) ? SIZE_MIN : (v > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : v;
    @(posedge clk);
  endtask

  task automatic run_message();
    int cap;
    int n;
    int pulls;
    cap = cur_size - HDR_LEN;
    case ($urandom_range(0, 9))
      0: n = cap;
      1: n = cap + $urandom_range(1, 3);
      2: n = $urandom_range(1, cap);
      default: n = $urandom_range(1, (cap < 12) ? cap : 12);
    endcase
    for (int i = 0; i < n; i++) send_item(REQ_PUSH, 8'($urandom_range(0, 255)), i == n - 1);
    case ($urandom_range(0, 5))
      0: pulls = $urandom_range(0, cur_size - 1);
      1: pulls = cur_size + $urandom_range(1, 3);
      default: pulls = cur_size;
    endcase
    for (int i = 0; i < pulls; i++) begin
      send_item(REQ_PULL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [8:0] sizes [10];
    int phase_end;
    sizes = '{9'd8, 9'd0, 9'd511, 9'd13, 9'd40, 9'd5, 9'd24, 9'd9, 9'd64, 9'd0};
    sizes[9] = 9'($urandom_range(0, 72));
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pull with nothing ready, at the reset block size; its data fields are ignored.
    send_item(REQ_PULL, 8'hFF, 1'b1);
    write_size(9'd8);
    // Two payload bytes leave a single pad byte, which holds the pad count.
    send_item(REQ_PUSH, 8'hFF, 1'b0);
    send_item(REQ_PUSH, 8'h00, 1'b1);
    repeat (8) send_item(REQ_PULL, 8'h00, 1'b0);
    // A full payload needs no padding.
    send_item(REQ_PUSH, 8'hAA, 1'b0);
    send_item(REQ_PUSH, 8'h55, 1'b0);
    send_item(REQ_PUSH, 8'hFF, 1'b1);
    send_item(REQ_PULL, 8'h00, 1'b0);
    // A push while that block is ready throws it away.
    send_item(REQ_PUSH, 8'h01, 1'b1);
    repeat (3) send_item(REQ_PULL, 8'hFF, 1'b1);
    // The fourth byte overflows and the message is dropped at its close.
    send_item(REQ_PUSH, 8'h80, 1'b0);
    send_item(REQ_PUSH, 8'h7F, 1'b0);
    send_item(REQ_PUSH, 8'hFE, 1'b0);
    send_item(REQ_PUSH, 8'h01, 1'b1);
    send_item(REQ_PULL, 8'h00, 1'b0);

    foreach (sizes[p]) begin
      write_size(sizes[p]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 4)) begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          end
          1: wait_idle();
          default: run_message();
        endcase
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/pbfc_pkg.sv
src/pbfc_ctrl.sv
src/pbfc_dp.sv
src/padded_block_formatter_checksum.sv
src/pbfc_checker.sv
verif/pbfc_checker.sv
verif/tb_top.sv
